// ===== sv/anchor_chaining_window_dp_core_defines.svh =====
// Assertion macros shared by the anchor chaining checker.
`ifndef ANCHOR_CHAINING_WINDOW_DP_CORE_DEFINES_SVH
`define ANCHOR_CHAINING_WINDOW_DP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACWDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anchor chaining check failed");

// Next-cycle implication.
`define ACWDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anchor chaining check failed");

`endif

// ===== sv/acwdp_pkg.sv =====
// Shared types and constants for the anchor chaining window core.
`default_nettype none

package acwdp_pkg;

    localparam int WINDOW  = 16;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);

    localparam int POS_W   = 31;
    localparam int SCORE_W = 24;
    localparam int TDATA_W = ((2 * POS_W + 7) / 8) * 8;
    localparam int MDATA_W = ((SCORE_W + 7) / 8) * 8;

    localparam int SEED_SCORE = 15;
    localparam int ALPHA_MAX  = 15;
    localparam int ALPHA_W    = 4;
    localparam int SCORE_MAX  = (1 << SCORE_W) - 1;

    // Gaps of 2^27 or more give a penalty above any reachable score.
    localparam int GAP_BITS    = 27;
    localparam int N_W         = GAP_BITS + 4;
    localparam int N4_W        = N_W - 2;
    // floor(n4 / 25) = (n4 * RECIP_M) >> RECIP_SHIFT for n4 < 2^29
    localparam int RECIP_W     = 30;
    localparam logic [RECIP_W-1:0] RECIP_M = 30'd687194768;
    localparam int RECIP_SHIFT = 34;
    localparam int PROD_W      = N4_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;

    localparam int BEST_W = SCORE_W + 1;
    localparam int CAND_W = Q_W + 2;

    typedef struct packed {
        logic             first;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } anchor_t;

endpackage

`default_nettype wire

// ===== sv/anchor_chaining_window_dp_core.sv =====
// Top level of the windowed anchor chaining core.
`default_nettype none

// Scores sorted seed anchors against the last 16 anchors of the current set.
// Each anchor beat on the slave side yields exactly one chain_score beat on the
// master side, in order. An anchor occupies the scoring engine while the ring is
// swept and drained (no sweep when the ring is empty or first_anchor is
// set): one ring entry enters a six-stage compare-add-max pipeline per cycle,
// and the next anchor starts only after this one's score is written back into
// the ring. A two-entry input queue and the output register let both sides
// keep moving while the engine works.
// Setting first_anchor empties the ring before that anchor is scored.

module anchor_chaining_window_dp_core
    import acwdp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // anchor_x, anchor_y, zero pad
    input  wire logic               s_tuser,   // first_anchor
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MDATA_W-1:0]      m_tdata    // chain_score
);

    logic    q_valid;
    logic    q_ready;
    anchor_t q_item;

    acwdp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    acwdp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/acwdp_front.sv =====
// Input side: unpacks anchor beats into a two-entry queue for the scoring engine.
`default_nettype none

module acwdp_front
    import acwdp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // anchor_x, anchor_y, zero pad
    input  wire logic               s_tuser,   // first_anchor
    output logic                    q_valid,
    input  wire logic               q_ready,
    output anchor_t                 q_item
);

    anchor_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    anchor_t     in_item;

    assign in_item.x     = s_tdata[POS_W-1:0];
    assign in_item.y     = s_tdata[2*POS_W-1:POS_W];
    assign in_item.first = s_tuser;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    assign push = s_tvalid & s_tready;
    assign pop  = q_valid & q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/acwdp_back.sv =====
// Scoring engine: sweeps the anchor ring through a compare-add-max pipeline.
`default_nettype none

module acwdp_back
    import acwdp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire anchor_t            q_item,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MDATA_W-1:0]      m_tdata    // chain_score
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // anchor ring
    logic [POS_W-1:0]   wx_reg [WINDOW];
    logic [POS_W-1:0]   wy_reg [WINDOW];
    logic [SCORE_W-1:0] ws_reg [WINDOW];

    logic [1:0]         state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]  idx_reg, idx_next;
    logic [FILL_W-1:0]  cnt_reg, cnt_next;
    logic [BEST_W-1:0]  best_reg, best_next;
    logic [POS_W-1:0]   cur_x_reg, cur_y_reg;
    logic               out_valid_reg, out_valid_next;
    logic [SCORE_W-1:0] out_data_reg;

    logic pop, issue, pipe_busy, finish;
    logic [SCORE_W-1:0] score_sat;

    // pipeline
    logic               p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    logic [POS_W-1:0]   p1_x_reg, p1_y_reg;
    logic [SCORE_W-1:0] p1_s_reg, p2_s_reg, p3_s_reg, p4_s_reg, p5_s_reg;
    logic signed [POS_W:0] p2_dx_reg, p2_dy_reg;
    logic               p3_ok_reg, p4_ok_reg, p5_ok_reg;
    logic [ALPHA_W-1:0] p3_alpha_reg, p4_alpha_reg, p5_alpha_reg;
    logic [POS_W-1:0]   p3_l_reg;
    logic [N4_W-1:0]    p4_n4_reg;
    logic               p4_lz_reg;
    logic [Q_W-1:0]     p5_q_reg;

    logic               s3_ok;
    logic [POS_W-1:0]   s3_mn, s3_l;
    logic [ALPHA_W-1:0] s3_alpha;
    logic [GAP_BITS-1:0] s4_l;
    logic [N_W-1:0]     s4_n;
    logic [PROD_W-1:0]  s5_prod;
    logic signed [CAND_W-1:0] s6_cand;
    logic               s6_win;

    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_valid & q_ready;
    assign issue     = (state_reg == ST_RUN) && (idx_reg < cnt_reg);
    assign pipe_busy = p1_v_reg | p2_v_reg | p3_v_reg | p4_v_reg | p5_v_reg;
    assign finish    = (state_reg == ST_DRAIN) && !pipe_busy && (!out_valid_reg || m_tready);
    assign score_sat = (best_reg > BEST_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX)
                                                       : best_reg[SCORE_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MDATA_W'(out_data_reg);

    // stage 3: predecessor test, alpha, gap difference
    always_comb
    begin
        s3_ok = !p2_dx_reg[POS_W] && (p2_dx_reg != '0) && !p2_dy_reg[POS_W] && (p2_dy_reg != '0);
        if (p2_dx_reg[POS_W-1:0] < p2_dy_reg[POS_W-1:0])
        begin
            s3_mn = p2_dx_reg[POS_W-1:0];
            s3_l  = p2_dy_reg[POS_W-1:0] - p2_dx_reg[POS_W-1:0];
        end
        else
        begin
            s3_mn = p2_dy_reg[POS_W-1:0];
            s3_l  = p2_dx_reg[POS_W-1:0] - p2_dy_reg[POS_W-1:0];
        end
        s3_alpha = (s3_mn > POS_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX) : s3_mn[ALPHA_W-1:0];
    end

    // stage 4: 15*l - 1, stage 5: divide by 100 via reciprocal
    assign s4_l    = p3_l_reg[GAP_BITS-1:0];
    assign s4_n    = ({s4_l, 4'b0000} - {4'b0000, s4_l}) - N_W'(1);
    assign s5_prod = PROD_W'(p4_n4_reg) * PROD_W'(RECIP_M);

    // stage 6: candidate and running max
    assign s6_cand = $signed(CAND_W'(p5_s_reg)) + $signed(CAND_W'(p5_alpha_reg))
                   - $signed(CAND_W'(p5_q_reg));
    assign s6_win  = p5_v_reg && p5_ok_reg && (s6_cand > $signed(CAND_W'(best_reg)));

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg & ~m_tready;

        if (s6_win)
        begin
            best_next = s6_cand[BEST_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    best_next = BEST_W'(SEED_SCORE);
                    idx_next  = '0;
                    if (q_item.first)
                    begin
                        fill_next = '0;
                        head_next = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        cnt_next = fill_reg;
                    end
                    state_next = (q_item.first || fill_reg == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                idx_next = idx_reg + FILL_W'(1);
                if (idx_reg + FILL_W'(1) >= cnt_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    head_next  = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);
                    if (fill_reg < FILL_W'(WINDOW))
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            p4_v_reg      <= 1'b0;
            p5_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            p1_v_reg      <= issue;
            p2_v_reg      <= p1_v_reg;
            p3_v_reg      <= p2_v_reg;
            p4_v_reg      <= p3_v_reg;
            p5_v_reg      <= p4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_x_reg <= q_item.x;
            cur_y_reg <= q_item.y;
        end
        if (finish)
        begin
            out_data_reg     <= score_sat;
            wx_reg[head_reg] <= cur_x_reg;
            wy_reg[head_reg] <= cur_y_reg;
            ws_reg[head_reg] <= score_sat;
        end

        p1_x_reg <= wx_reg[idx_reg[IDX_W-1:0]];
        p1_y_reg <= wy_reg[idx_reg[IDX_W-1:0]];
        p1_s_reg <= ws_reg[idx_reg[IDX_W-1:0]];

        p2_dx_reg <= $signed({1'b0, cur_x_reg}) - $signed({1'b0, p1_x_reg});
        p2_dy_reg <= $signed({1'b0, cur_y_reg}) - $signed({1'b0, p1_y_reg});
        p2_s_reg  <= p1_s_reg;

        p3_ok_reg    <= s3_ok;
        p3_alpha_reg <= s3_alpha;
        p3_l_reg     <= s3_l;
        p3_s_reg     <= p2_s_reg;

        p4_n4_reg    <= s4_n[N_W-1:2];
        p4_lz_reg    <= (p3_l_reg == '0);
        p4_ok_reg    <= p3_ok_reg && (p3_l_reg[POS_W-1:GAP_BITS] == '0);
        p4_alpha_reg <= p3_alpha_reg;
        p4_s_reg     <= p3_s_reg;

        p5_q_reg     <= p4_lz_reg ? '0 : s5_prod[PROD_W-1:RECIP_SHIFT];
        p5_ok_reg    <= p4_ok_reg;
        p5_alpha_reg <= p4_alpha_reg;
        p5_s_reg     <= p4_s_reg;
    end

endmodule

`default_nettype wire

// ===== sv/acwdp_checker.sv =====
// Port-level checker for the anchor chaining core, bound to the top level.
`default_nettype none

`include "anchor_chaining_window_dp_core_defines.svh"

module acwdp_checker
    import acwdp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [TDATA_W-1:0] s_tdata,
    input wire logic               s_tuser,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [MDATA_W-1:0] m_tdata
);

    // queue, engine and output register together hold at most four anchors
    localparam logic [2:0] PENDING_MAX = 3'd4;

    logic [2:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid & s_tready;
    assign out_beat = m_tvalid & m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ACWDP_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready,
                       s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    `ACWDP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `ACWDP_ASSERT_IMPL(a_score_floor, m_tvalid, m_tdata >= MDATA_W'(SEED_SCORE))
    `ACWDP_ASSERT_IMPL(a_no_extra_beat, m_tvalid, pending_reg != 3'd0)
    `ACWDP_ASSERT_IMPL(a_capacity, 1'b1, pending_reg <= PENDING_MAX)

endmodule

bind anchor_chaining_window_dp_core acwdp_checker u_acwdp_checker (.*);

`default_nettype wire
